// File: rtl/core/epcs_pkg.sv
// ----------------------------------------------------------------------------
// Event pair correlation search package
// Shared types, register map and reset values of the pair search block.
// ----------------------------------------------------------------------------
package epcs_pkg;

    localparam int unsigned DEF_RECORD_DEPTH = 4096;
    localparam int unsigned APB_ADDR_W       = 5;
    localparam int unsigned APB_DATA_W       = 32;
    localparam int unsigned LOW_W            = 12;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_SECOND_CODE = 3'd0;
    localparam t_reg_idx REG_FIRST_CODE  = 3'd1;
    localparam t_reg_idx REG_SECOND_LOW  = 3'd2;
    localparam t_reg_idx REG_FIRST_LOW   = 3'd3;
    localparam t_reg_idx REG_ADDR_WIN    = 3'd4;
    localparam t_reg_idx REG_TIME_WIN    = 3'd5;

    localparam logic [7:0]       RST_SECOND_CODE = 8'd2;
    localparam logic [7:0]       RST_FIRST_CODE  = 8'd1;
    localparam logic [LOW_W-1:0] RST_SECOND_LOW  = 12'h1e1;
    localparam logic [LOW_W-1:0] RST_FIRST_LOW   = 12'h1d5;
    localparam logic [15:0]      RST_ADDR_WIN    = 16'd16;
    localparam logic [31:0]      RST_TIME_WIN    = 32'd300;

    typedef struct packed {
        logic [63:0] mem_address;
        logic [7:0]  event_code;
        logic [63:0] time_stamp;
        logic [21:0] process_id;
        logic        last_record;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [63:0] first_address;
        logic [63:0] second_address;
        logic [21:0] owner_id;
    } t_out;

    typedef struct packed {
        logic [63:0] address;
        logic [7:0]  code;
        logic [63:0] stamp;
    } t_rec;

    typedef struct packed {
        logic [7:0]       second_code;
        logic [7:0]       first_code;
        logic [LOW_W-1:0] second_low;
        logic [LOW_W-1:0] first_low;
        logic [15:0]      addr_window;
        logic [31:0]      time_window;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_L,
        S_CHECK_L,
        S_READ_E,
        S_CHECK_E,
        S_DIFF,
        S_TEST,
        S_EMIT
    } t_state;

endpackage

// File: rtl/core/epcs_cfg.sv
// ----------------------------------------------------------------------------
// Pair search configuration registers
// APB register file holding the match rules and the two windows.
// ----------------------------------------------------------------------------
module epcs_cfg
    import epcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_xfer;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_xfer = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.second_code <= RST_SECOND_CODE;
            r_cfg.first_code  <= RST_FIRST_CODE;
            r_cfg.second_low  <= RST_SECOND_LOW;
            r_cfg.first_low   <= RST_FIRST_LOW;
            r_cfg.addr_window <= RST_ADDR_WIN;
            r_cfg.time_window <= RST_TIME_WIN;
        end else if (wr_xfer) begin
            unique case (reg_idx)
                REG_SECOND_CODE: r_cfg.second_code <= pwdata[7:0];
                REG_FIRST_CODE:  r_cfg.first_code  <= pwdata[7:0];
                REG_SECOND_LOW:  r_cfg.second_low  <= pwdata[LOW_W-1:0];
                REG_FIRST_LOW:   r_cfg.first_low   <= pwdata[LOW_W-1:0];
                REG_ADDR_WIN:    r_cfg.addr_window <= pwdata[15:0];
                REG_TIME_WIN:    r_cfg.time_window <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SECOND_CODE: prdata = {24'd0, r_cfg.second_code};
            REG_FIRST_CODE:  prdata = {24'd0, r_cfg.first_code};
            REG_SECOND_LOW:  prdata = {20'd0, r_cfg.second_low};
            REG_FIRST_LOW:   prdata = {20'd0, r_cfg.first_low};
            REG_ADDR_WIN:    prdata = {16'd0, r_cfg.addr_window};
            REG_TIME_WIN:    prdata = r_cfg.time_window;
            default:         prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/epcs_store.sv
// ----------------------------------------------------------------------------
// Pair search record store
// Simple dual-port record memory with a registered read.
// ----------------------------------------------------------------------------
module epcs_store
    import epcs_pkg::*;
#(
    parameter int unsigned RECORD_DEPTH = DEF_RECORD_DEPTH,
    localparam int unsigned AW = $clog2(RECORD_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_rec          i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_rec          o_rd_data
);

    t_rec r_mem [RECORD_DEPTH];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/event_pair_correlation_search.sv
// Records load back to back, 1 per cycle, while the block is idle and takes input.
// After the last record, the backward scan runs on the single memory read port:
// each record visited by the outer scan or skipped by the inner scan is read, then checked;
// each first-kind candidate is read, checked, differenced and tested; then the result is posted.
// Input is refused while the scan runs; a finished result waits in an output register.
// Reset is synchronous: configuration registers return to defaults, state, valid and record count clear at once.
// ----------------------------------------------------------------------------
// Event pair correlation search
// Stores event records and searches them backwards for a close pair of kinds.
// ----------------------------------------------------------------------------
module event_pair_correlation_search
    import epcs_pkg::*;
#(
    parameter int unsigned RECORD_DEPTH = DEF_RECORD_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data
);

    localparam int unsigned AW = $clog2(RECORD_DEPTH);
    localparam int unsigned CW = $clog2(RECORD_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(RECORD_DEPTH);

    t_cfg   cfg;
    t_rec   rd_data;
    t_rec   wr_data;
    logic   wr_en;
    logic   rd_en;
    logic [AW-1:0] rd_addr;

    t_state        r_state,  n_state;
    logic [CW-1:0] r_count,  n_count;
    logic [AW-1:0] r_l,      n_l;
    logic [AW-1:0] r_e,      n_e;
    logic [63:0]   r_x,      n_x;
    logic [63:0]   r_tj,     n_tj;
    logic [63:0]   r_dist,   n_dist;
    logic [63:0]   r_tdiff,  n_tdiff;
    logic          r_hit,    n_hit;
    logic [63:0]   r_first,  n_first;
    logic [63:0]   r_second, n_second;
    logic [21:0]   r_pid,    n_pid;
    logic          r_ovalid, n_ovalid;
    t_out          r_out,    n_out;

    logic          in_xfer;
    logic          wr_space;
    logic [CW-1:0] batch_n;
    logic          second_kind;
    logic          first_kind;
    logic          too_far;
    logic          too_late;

    epcs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign wr_data.address = i_in_data.mem_address;
    assign wr_data.code    = i_in_data.event_code;
    assign wr_data.stamp   = i_in_data.time_stamp;

    epcs_store #(
        .RECORD_DEPTH (RECORD_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // A full store drops the record but still counts the batch as it stands.
    assign wr_space = (r_count != DEPTH_CNT);
    assign batch_n  = r_count + {{(CW-1){1'b0}}, wr_space};

    assign second_kind = (rd_data.code == cfg.second_code) &&
                         (rd_data.address[LOW_W-1:0] == cfg.second_low);
    assign first_kind  = (rd_data.code == cfg.first_code) &&
                         (rd_data.address[LOW_W-1:0] == cfg.first_low);
    assign too_far     = (|r_dist[63:16]) || (r_dist[15:0] > cfg.addr_window);
    assign too_late    = (|r_tdiff[63:32]) || (r_tdiff[31:0] > cfg.time_window);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_l      = r_l;
        n_e      = r_e;
        n_x      = r_x;
        n_tj     = r_tj;
        n_dist   = r_dist;
        n_tdiff  = r_tdiff;
        n_hit    = r_hit;
        n_first  = r_first;
        n_second = r_second;
        n_pid    = r_pid;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_l;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    wr_en = wr_space;
                    if (wr_space) begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_in_data.last_record) begin
                        n_count = '0;
                        n_pid   = i_in_data.process_id;
                        if (batch_n <= CW'(1)) begin
                            n_hit    = 1'b0;
                            n_first  = '0;
                            n_second = '0;
                            n_state  = S_EMIT;
                        end else begin
                            n_l     = AW'(batch_n - CW'(1));
                            n_state = S_READ_L;
                        end
                    end
                end
            end
            S_READ_L: begin
                rd_en   = 1'b1;
                rd_addr = r_l;
                n_state = S_CHECK_L;
            end
            S_CHECK_L: begin
                if (second_kind) begin
                    n_x     = rd_data.address;
                    n_tj    = rd_data.stamp;
                    n_e     = r_l - AW'(1);
                    n_state = S_READ_E;
                end else if (r_l == AW'(1)) begin
                    n_hit    = 1'b0;
                    n_first  = '0;
                    n_second = '0;
                    n_state  = S_EMIT;
                end else begin
                    n_l     = r_l - AW'(1);
                    n_state = S_READ_L;
                end
            end
            S_READ_E: begin
                rd_en   = 1'b1;
                rd_addr = r_e;
                n_state = S_CHECK_E;
            end
            S_CHECK_E: begin
                if (first_kind) begin
                    n_state = S_DIFF;
                end else if (r_e == '0) begin
                    n_hit    = 1'b0;
                    n_first  = '0;
                    n_second = '0;
                    n_state  = S_EMIT;
                end else begin
                    n_e     = r_e - AW'(1);
                    n_state = S_READ_E;
                end
            end
            S_DIFF: begin
                n_dist  = (r_x >= rd_data.address) ? (r_x - rd_data.address)
                                                   : (rd_data.address - r_x);
                n_tdiff = r_tj - rd_data.stamp;
                n_state = S_TEST;
            end
            S_TEST: begin
                // The read register still holds the earlier record here.
                if (!too_far && !too_late) begin
                    n_hit    = 1'b1;
                    n_first  = rd_data.address;
                    n_second = r_x;
                    n_state  = S_EMIT;
                end else if (r_e == '0) begin
                    n_hit    = 1'b0;
                    n_first  = '0;
                    n_second = '0;
                    n_state  = S_EMIT;
                end else if (too_far) begin
                    n_e     = r_e - AW'(1);
                    n_state = S_READ_E;
                end else begin
                    // Timestamps too far apart: the outer scan resumes at this record.
                    n_l     = r_e;
                    n_state = S_READ_L;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid             = 1'b1;
                    n_out.found          = r_hit;
                    n_out.first_address  = r_first;
                    n_out.second_address = r_second;
                    n_out.owner_id       = r_pid;
                    n_state              = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l      <= n_l;
        r_e      <= n_e;
        r_x      <= n_x;
        r_tj     <= n_tj;
        r_dist   <= n_dist;
        r_tdiff  <= n_tdiff;
        r_hit    <= n_hit;
        r_first  <= n_first;
        r_second <= n_second;
        r_pid    <= n_pid;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    ap_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("record count beyond store depth");

    ap_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !wr_en)
        else $error("store written while a scan is running");

    ap_later_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ_L) |-> (r_l != '0))
        else $error("outer scan reached the oldest record");

    ap_earlier_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ_E) |-> (r_e < r_l))
        else $error("inner scan index not below the later record");

    ap_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.last_record) |=> (r_count == '0 && r_state != S_IDLE))
        else $error("batch end did not clear the count and start the scan");
`endif

endmodule
